@@ hw/rtl/sm4_pkg.sv @@
// ----------------------------------------------------------------------------
// SM4 package
// Shared constants, control structs and round-function helpers for the
// SM4 block cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package sm4_pkg;

  // Number of rounds of the cipher and of the key schedule.
  localparam int unsigned Rounds = 32;
  localparam int unsigned RndW   = $clog2(Rounds);

  // Word width of the cipher state.
  localparam int unsigned WordW  = 32;

  // Register indexes of the configuration port.
  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  // System parameter FK.
  localparam logic [WordW-1:0] FK0 = 32'hA3B1BAC6;
  localparam logic [WordW-1:0] FK1 = 32'h56AA3350;
  localparam logic [WordW-1:0] FK2 = 32'h677D9197;
  localparam logic [WordW-1:0] FK3 = 32'hB27022DC;

  // Control of one cell of the state-word chain.
  typedef struct packed {
    logic load;   // take the load value
    logic shift;  // take the neighbor's word
  } word_ctl_t;

  // Control of one cell of the round-key ring.
  typedef struct packed {
    logic shift;  // move one place along the ring
    logic rev;    // take from the lower neighbor instead of the upper one
  } key_ctl_t;

  // SM4 S-box.
  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Byte-wise S-box substitution of one word.
  function automatic logic [WordW-1:0] subst(input logic [WordW-1:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

  // Data-round transform T: substitution followed by the linear map L.
  function automatic logic [WordW-1:0] t_data(input logic [WordW-1:0] v);
    logic [WordW-1:0] b;
    b = subst(v);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  // Key-schedule transform T': substitution followed by the linear map L'.
  function automatic logic [WordW-1:0] t_key(input logic [WordW-1:0] v);
    logic [WordW-1:0] b;
    b = subst(v);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // Round constant CK: byte j of round i is (4*i + j) * 7 modulo 256.
  function automatic logic [WordW-1:0] ck_word(input logic [RndW-1:0] i);
    logic [WordW-1:0] w;
    logic [7:0]       idx;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      idx = {1'b0, i, 2'(j)};
      w   = {w[WordW-9:0], 8'(idx * 8'd7)};
    end
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sm4_word_cell.sv @@
// ----------------------------------------------------------------------------
// SM4 state-word cell
// Holds one 32-bit word of the round state; it loads a fresh word, takes
// the word of its upper neighbor in the chain, or keeps its word.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_word_cell (
  input  wire logic                           clk_i,
  input  wire sm4_pkg::word_ctl_t             ctl_i,
  input  wire logic [sm4_pkg::WordW-1:0]      load_i,
  input  wire logic [sm4_pkg::WordW-1:0]      next_i,
  output logic      [sm4_pkg::WordW-1:0]      word_o
);

  logic [sm4_pkg::WordW-1:0] word_q;

  // Load has priority over the shift along the chain.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      word_q <= load_i;
    end else if (ctl_i.shift) begin
      word_q <= next_i;
    end
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

@@ hw/rtl/sm4_key_cell.sv @@
// ----------------------------------------------------------------------------
// SM4 round-key cell
// Holds one round key of the key ring; the ring turns in either direction
// so that encryption reads the keys at one end and decryption at the other.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_key_cell (
  input  wire logic                           clk_i,
  input  wire sm4_pkg::key_ctl_t              ctl_i,
  input  wire logic [sm4_pkg::WordW-1:0]      next_i,
  input  wire logic [sm4_pkg::WordW-1:0]      prev_i,
  output logic      [sm4_pkg::WordW-1:0]      rk_o
);

  logic [sm4_pkg::WordW-1:0] rk_q;

  // Move one place: forward takes the upper neighbor, reverse the lower one.
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      rk_q <= ctl_i.rev ? prev_i : next_i;
    end
  end

  assign rk_o = rk_q;

endmodule

`default_nettype wire

@@ hw/rtl/sm4_round.sv @@
// ----------------------------------------------------------------------------
// SM4 round function
// Computes the new state word X0 ^ T(X1 ^ X2 ^ X3 ^ K), with T for data
// rounds and T' for key-schedule rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_round (
  input  wire logic                           key_mode_i,
  input  wire logic [sm4_pkg::WordW-1:0]      x0_i,
  input  wire logic [sm4_pkg::WordW-1:0]      x1_i,
  input  wire logic [sm4_pkg::WordW-1:0]      x2_i,
  input  wire logic [sm4_pkg::WordW-1:0]      x3_i,
  input  wire logic [sm4_pkg::WordW-1:0]      rk_i,
  output logic      [sm4_pkg::WordW-1:0]      nx_o
);

  logic [sm4_pkg::WordW-1:0] mix;
  logic [sm4_pkg::WordW-1:0] tout;

  // Mix three words with the round key, then apply the selected transform.
  always_comb begin
    mix  = x1_i ^ x2_i ^ x3_i ^ rk_i;
    tout = key_mode_i ? sm4_pkg::t_key(mix) : sm4_pkg::t_data(mix);
    nx_o = x0_i ^ tout;
  end

endmodule

`default_nettype wire

@@ hw/rtl/sm4_block_cipher_core.sv @@
// ----------------------------------------------------------------------------
// SM4 block cipher core
// Encrypts or decrypts one 128-bit block with a 128-bit key in 32 rounds.
// ----------------------------------------------------------------------------
// Usage:
// The key is written through the configuration port: index 0 holds key
// words 0 and 1, index 1 holds key words 2 and 3. A key write while busy
// is low marks the round keys stale. Write the key only while busy is low.
// A block transfer takes place at a clock edge with start high and busy
// low; mode_i selects encryption (0) or decryption (1).
// The state is a chain of four word cells fed by one round unit, through
// which the rounds of each block run in turn. The result shows on
// out0_o..out3_o with done_o high for one cycle. The first block after
// reset or after a key write first runs the key schedule through the same
// round unit, filling a ring of 32 round-key cells, before its cipher
// rounds. busy is low in the cycle done_o is high, so a new block can
// follow at once. The results cannot be stalled; the receiver must take
// each one as it appears. Reset clears the key to zero and marks the
// round keys stale.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_block_cipher_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Block input.
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode_i,
  input  wire logic [31:0] word0_i,
  input  wire logic [31:0] word1_i,
  input  wire logic [31:0] word2_i,
  input  wire logic [31:0] word3_i,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  // Result output.
  output logic             done_o,
  output logic [31:0]      out0_o,
  output logic [31:0]      out1_o,
  output logic [31:0]      out2_o,
  output logic [31:0]      out3_o
);

  localparam int unsigned Rounds = sm4_pkg::Rounds;
  localparam int unsigned RndW   = sm4_pkg::RndW;
  localparam int unsigned WordW  = sm4_pkg::WordW;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXPAND = 2'd1;
  localparam logic [1:0] ST_CIPHER = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [RndW-1:0]  cnt_q, cnt_d;
  logic             keys_ready_q, keys_ready_d;
  logic             done_q, done_d;
  logic [63:0]      key_high_q, key_low_q;
  logic             mode_q;
  logic [WordW-1:0] blk_q [4];
  logic [WordW-1:0] out_q [4];

  logic             accept;
  logic             last_rnd;
  logic             expanding;
  logic [WordW-1:0] x     [4];
  logic [WordW-1:0] xload [4];
  logic [WordW-1:0] rk_ring [Rounds];
  logic [WordW-1:0] rk_sel;
  logic [WordW-1:0] nx;

  sm4_pkg::word_ctl_t word_ctl;
  sm4_pkg::key_ctl_t  key_ctl;

  assign accept    = start && (state_q == ST_IDLE);
  assign last_rnd  = (cnt_q == RndW'(Rounds - 1));
  assign expanding = (state_q == ST_EXPAND);
  assign busy      = (state_q != ST_IDLE);

  // Sequencer: optional key schedule, then the cipher rounds.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    keys_ready_d = keys_ready_q;
    done_d       = 1'b0;
    word_ctl     = '0;
    key_ctl      = '0;
    for (int k = 0; k < 4; k++) begin
      xload[k] = blk_q[k];
    end
    case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          keys_ready_d = 1'b0;
        end
        if (accept) begin
          word_ctl.load = 1'b1;
          cnt_d         = '0;
          if (keys_ready_q) begin
            xload   = '{word0_i, word1_i, word2_i, word3_i};
            state_d = ST_CIPHER;
          end else begin
            xload   = '{key_high_q[63:32] ^ sm4_pkg::FK0, key_high_q[31:0] ^ sm4_pkg::FK1,
                        key_low_q[63:32] ^ sm4_pkg::FK2, key_low_q[31:0] ^ sm4_pkg::FK3};
            state_d = ST_EXPAND;
          end
        end
      end
      ST_EXPAND: begin
        word_ctl.shift = 1'b1;
        key_ctl.shift  = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (last_rnd) begin
          word_ctl.load = 1'b1;
          keys_ready_d  = 1'b1;
          state_d       = ST_CIPHER;
        end
      end
      ST_CIPHER: begin
        word_ctl.shift = 1'b1;
        key_ctl.shift  = 1'b1;
        key_ctl.rev    = mode_q;
        cnt_d          = cnt_q + 1'b1;
        if (last_rnd) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      keys_ready_q <= 1'b0;
      done_q       <= 1'b0;
      key_high_q   <= '0;
      key_low_q    <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      keys_ready_q <= keys_ready_d;
      done_q       <= done_d;
      if (cfg_we_i && (cfg_idx_i == sm4_pkg::CFG_KEY_HIGH)) begin
        key_high_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == sm4_pkg::CFG_KEY_LOW)) begin
        key_low_q <= cfg_wdata_i;
      end
    end
  end

  // Block and mode captured on each transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      blk_q  <= '{word0_i, word1_i, word2_i, word3_i};
    end
  end

  // Round key: the CK constant while expanding, else the ring's read end.
  assign rk_sel = expanding ? sm4_pkg::ck_word(cnt_q)
                            : (mode_q ? rk_ring[Rounds-1] : rk_ring[0]);

  sm4_round u_round (
    .key_mode_i (expanding),
    .x0_i       (x[0]),
    .x1_i       (x[1]),
    .x2_i       (x[2]),
    .x3_i       (x[3]),
    .rk_i       (rk_sel),
    .nx_o       (nx)
  );

  // State-word chain: each cell takes its upper neighbor, the top one the new word.
  for (genvar k = 0; k < 4; k++) begin : g_word
    logic [WordW-1:0] next_w;
    if (k == 3) begin : g_top
      assign next_w = nx;
    end else begin : g_mid
      assign next_w = x[k+1];
    end
    sm4_word_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (word_ctl),
      .load_i (xload[k]),
      .next_i (next_w),
      .word_o (x[k])
    );
  end

  // Round-key ring; while expanding, new keys enter at the top end.
  for (genvar k = 0; k < Rounds; k++) begin : g_key
    logic [WordW-1:0] next_k;
    logic [WordW-1:0] prev_k;
    if (k == Rounds - 1) begin : g_top
      assign next_k = expanding ? nx : rk_ring[0];
    end else begin : g_mid
      assign next_k = rk_ring[k+1];
    end
    if (k == 0) begin : g_bot
      assign prev_k = rk_ring[Rounds-1];
    end else begin : g_up
      assign prev_k = rk_ring[k-1];
    end
    sm4_key_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (key_ctl),
      .next_i (next_k),
      .prev_i (prev_k),
      .rk_o   (rk_ring[k])
    );
  end

  // Result register: the last four state words in reverse order.
  always_ff @(posedge clk_i) begin
    if (done_d) begin
      out_q <= '{nx, x[3], x[2], x[1]};
    end
  end

  assign done_o = done_q;
  assign out0_o = out_q[0];
  assign out1_o = out_q[1];
  assign out2_o = out_q[2];
  assign out3_o = out_q[3];

endmodule

`default_nettype wire
